[rtl/core/rsi_pkg.sv]
// Shared widths, constants and the pipeline item type for the ray/sphere core.
// No dependencies.
package rsi_pkg;
   localparam int CB = 16;
   localparam int AW = 2 * CB;
   localparam int HW = 2 * CB + 1;
   localparam int CW = 2 * CB + 2;
   localparam int DW = 4 * CB + 4;
   localparam int RW = 2 * CB + 1;
   localparam int NW = RW + 2;
   localparam int TW = 32;
   localparam int FB = 16;
   localparam int IB = TW - 1 - FB;
   localparam int QB = TW - 1;
   localparam int QW = AW + QB;
   localparam int XW = 6;
   localparam logic [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_FAR  = 2'd1;
   localparam logic [1:0] CNT_BOTH = 2'd2;

   typedef struct packed {
      logic [AW-1:0]        a;
      logic signed [HW-1:0] h;
      logic [DW-1:0]        srem;
      logic [RW-1:0]        root;
      logic                 degen;
      logic                 live;
      logic [1:0]           cnt;
      logic                 sat1;
      logic                 sat2;
      logic [QW-1:0]        drem1;
      logic [QW-1:0]        drem2;
      logic [QB-1:0]        q1;
      logic [QB-1:0]        q2;
   } rsi_item_type;
endpackage

[rtl/core/ray_sphere_intersect_core.sv]
// Ray/sphere intersection core: one ray per beat through a chain of cells.
// Depends on rsi_pkg, rsi_front, rsi_sqrt_cell, rsi_split, rsi_div_cell.
//
// Usage:
//   req channel: one beat carries a ray in the sphere frame (origin, direction,
//   signed Q8.8) and the radius (unsigned Q8.8).
//   rsp channel: one beat per request: hit count, two Q16.16 distances in
//   ascending order, degenerate and saturated flags.
// Pipeline: a request passes 4 front-end stages, 33 square-root cells, 1 numerator
//   stage, 31 divider cells and the output register before its response is valid.
// Throughput: one beat per cycle while the output is not stalled; every cell handles
//   one bit of the square root or of both quotients and passes its item on whenever the chain advances.
// Stall: when rsp_tready is low with a response held, the whole chain freezes and
//   req_tready drops; while the output register is empty or being taken, the
//   chain keeps moving and a new request is taken every cycle.
// Reset: synchronous, clears all valid bits; no response is pending after it.
module ray_sphere_intersect_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, sphere_radius (16 each)
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_count[2], t_first[32], t_second[32], degenerate[1], saturated[1], pad[4]
   output logic [71:0]  rsp_tdata
);
   import rsi_pkg::*;

   logic advance;
   logic front_valid;
   rsi_item_type front_item;
   logic sq_valid [RW+1];
   rsi_item_type sq_item [RW+1];
   logic dv_valid [QB+1];
   rsi_item_type dv_item [QB+1];
   logic rsp_valid_ff;
   logic [71:0] rsp_data_ff, rsp_data_in;
   rsi_item_type fin;
   logic [TW-1:0] t1, t2;
   logic sat;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   rsi_front u_front (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_tvalid),
      .o_x(req_tdata[15:0]), .o_y(req_tdata[31:16]), .o_z(req_tdata[47:32]),
      .d_x(req_tdata[63:48]), .d_y(req_tdata[79:64]), .d_z(req_tdata[95:80]),
      .rad(req_tdata[111:96]), .out_valid(front_valid), .out_item(front_item)
   );

   assign sq_valid[0] = front_valid;
   assign sq_item[0]  = front_item;

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      rsi_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .bit_idx(XW'(RW - 1 - i)),
         .in_valid(sq_valid[i]), .in_item(sq_item[i]),
         .out_valid(sq_valid[i+1]), .out_item(sq_item[i+1])
      );
   end

   rsi_split u_split (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(sq_valid[RW]), .in_item(sq_item[RW]),
      .out_valid(dv_valid[0]), .out_item(dv_item[0])
   );

   for (genvar i = 0; i < QB; i++) begin : g_div
      rsi_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .bit_idx(XW'(QB - 1 - i)),
         .in_valid(dv_valid[i]), .in_item(dv_item[i]),
         .out_valid(dv_valid[i+1]), .out_item(dv_item[i+1])
      );
   end

   always_comb begin
      fin = dv_item[QB];
      t1 = '0;
      t2 = '0;
      sat = 1'b0;
      if (fin.cnt != CNT_NONE) begin
         t1 = fin.sat1 ? T_MAX : TW'(fin.q1);
         sat = fin.sat1;
      end
      if (fin.cnt == CNT_BOTH) begin
         t2 = fin.sat2 ? T_MAX : TW'(fin.q2);
         sat = fin.sat1 || fin.sat2;
      end
      rsp_data_in = {4'b0, sat, fin.degen, t2, t1, fin.cnt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("hit count out of range");
   a_degen_nohit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |-> rsp_tdata[1:0] == CNT_NONE && rsp_tdata[67] == 1'b0)
      else $error("degenerate ray reported a hit");
   a_order : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == CNT_BOTH |->
         $signed(rsp_tdata[33:2]) <= $signed(rsp_tdata[65:34]))
      else $error("hits out of order");
   a_nohit_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == CNT_NONE |-> rsp_tdata[65:2] == '0)
      else $error("nonzero distance without hit");
   a_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");
`endif
endmodule

[rtl/core/rsi_front.sv]
// Front end: products, a/h/c sums, h*h and a*c, discriminant (four stages).
// Depends on rsi_pkg.
module rsi_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic signed [rsi_pkg::CB-1:0] o_x,
   input  logic signed [rsi_pkg::CB-1:0] o_y,
   input  logic signed [rsi_pkg::CB-1:0] o_z,
   input  logic signed [rsi_pkg::CB-1:0] d_x,
   input  logic signed [rsi_pkg::CB-1:0] d_y,
   input  logic signed [rsi_pkg::CB-1:0] d_z,
   input  logic [rsi_pkg::CB-1:0]        rad,
   output logic                        out_valid,
   output rsi_pkg::rsi_item_type       out_item
);
   import rsi_pkg::*;

   logic [3:0] v_ff;
   logic signed [AW-1:0] dd0_ff, dd1_ff, dd2_ff, do0_ff, do1_ff, do2_ff;
   logic signed [AW-1:0] oo0_ff, oo1_ff, oo2_ff;
   logic [AW-1:0] rr_ff;
   logic [AW-1:0] a_ff, a3_ff;
   logic signed [HW-1:0] h_ff, h3_ff;
   logic signed [CW-1:0] c_ff;
   logic signed [DW-1:0] hh_ff, ac_ff;
   logic degen_ff;
   rsi_item_type item_ff, item_in;
   logic signed [DW-1:0] disc;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dd0_ff <= d_x * d_x;
         dd1_ff <= d_y * d_y;
         dd2_ff <= d_z * d_z;
         do0_ff <= d_x * o_x;
         do1_ff <= d_y * o_y;
         do2_ff <= d_z * o_z;
         oo0_ff <= o_x * o_x;
         oo1_ff <= o_y * o_y;
         oo2_ff <= o_z * o_z;
         rr_ff  <= rad * rad;
         a_ff   <= AW'(dd0_ff + dd1_ff + dd2_ff);
         h_ff   <= HW'(do0_ff) + HW'(do1_ff) + HW'(do2_ff);
         c_ff   <= CW'(oo0_ff) + CW'(oo1_ff) + CW'(oo2_ff) - $signed(CW'(rr_ff));
         hh_ff  <= h_ff * h_ff;
         ac_ff  <= $signed({1'b0, a_ff}) * c_ff;
         a3_ff  <= a_ff;
         h3_ff  <= h_ff;
         degen_ff <= (a_ff == '0);
         item_ff <= item_in;
      end
   end

   always_comb begin
      disc = hh_ff - ac_ff;
      item_in = '0;
      item_in.a = a3_ff;
      item_in.h = h3_ff;
      item_in.degen = degen_ff;
      item_in.live = !degen_ff && !disc[DW-1];
      item_in.srem = item_in.live ? disc : '0;
   end

   assign out_valid = v_ff[3];
   assign out_item  = item_ff;
endmodule

[rtl/core/rsi_sqrt_cell.sv]
// One root bit of the floored square root of the discriminant.
// Depends on rsi_pkg.
module rsi_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [rsi_pkg::XW-1:0] bit_idx,
   input  logic                  in_valid,
   input  rsi_pkg::rsi_item_type in_item,
   output logic                  out_valid,
   output rsi_pkg::rsi_item_type out_item
);
   import rsi_pkg::*;

   logic valid_ff;
   rsi_item_type item_ff, item_in;
   logic [DW-1:0] trial;

   always_comb begin
      item_in = in_item;
      trial = (DW'(in_item.root) << (bit_idx + XW'(1))) + (DW'(1) << (2 * bit_idx));
      if (in_item.srem >= trial) begin
         item_in.srem = in_item.srem - trial;
         item_in.root = in_item.root | (RW'(1) << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[rtl/core/rsi_split.sv]
// Forms near/far numerators, hit count, range check and divider start values.
// Depends on rsi_pkg.
module rsi_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rsi_pkg::rsi_item_type in_item,
   output logic                  out_valid,
   output rsi_pkg::rsi_item_type out_item
);
   import rsi_pkg::*;

   logic valid_ff;
   rsi_item_type item_ff, item_in;
   logic signed [NW-1:0] nh, far_n, near_n;
   logic [QW-1:0] num1, num2, lim;

   always_comb begin
      nh     = -NW'(in_item.h);
      far_n  = nh + $signed(NW'(in_item.root));
      near_n = nh - $signed(NW'(in_item.root));
      item_in = in_item;
      item_in.cnt = CNT_NONE;
      if (in_item.live && !far_n[NW-1]) begin
         item_in.cnt = near_n[NW-1] ? CNT_FAR : CNT_BOTH;
      end
      num1 = (item_in.cnt == CNT_BOTH) ? QW'(unsigned'(near_n)) : QW'(unsigned'(far_n));
      num2 = QW'(unsigned'(far_n));
      if (item_in.cnt == CNT_NONE) begin
         num1 = '0;
         num2 = '0;
      end
      lim = QW'(in_item.a) << IB;
      item_in.sat1  = (num1 >= lim);
      item_in.sat2  = (num2 >= lim);
      item_in.drem1 = num1 << FB;
      item_in.drem2 = num2 << FB;
      item_in.q1 = '0;
      item_in.q2 = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[rtl/core/rsi_div_cell.sv]
// One quotient bit of both distance divisions (restoring, shared divisor a).
// Depends on rsi_pkg.
module rsi_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [rsi_pkg::XW-1:0] bit_idx,
   input  logic                  in_valid,
   input  rsi_pkg::rsi_item_type in_item,
   output logic                  out_valid,
   output rsi_pkg::rsi_item_type out_item
);
   import rsi_pkg::*;

   logic valid_ff;
   rsi_item_type item_ff, item_in;
   logic [QW-1:0] dv;

   always_comb begin
      item_in = in_item;
      dv = QW'(in_item.a) << bit_idx;
      if (in_item.drem1 >= dv) begin
         item_in.drem1 = in_item.drem1 - dv;
         item_in.q1 = in_item.q1 | (QB'(1) << bit_idx);
      end
      if (in_item.drem2 >= dv) begin
         item_in.drem2 = in_item.drem2 - dv;
         item_in.q2 = in_item.q2 | (QB'(1) << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
